// ----- rtl/core/oobf_pkg.sv -----
// ----------------------------------------------------------------------------
// oobf_pkg
// Shared types and constants for the overwrite-oldest byte FIFO.
// ----------------------------------------------------------------------------
package oobf_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int BYTE_W    = 8;
	localparam int FILL_W    = 5;
	localparam int KIND_W    = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_POP    = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // input transfer this cycle
		logic load_now;   // load result register from the operation itself
		logic load_read;  // load result register from store read data
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_read;  // offered item is a pop on a non-empty buffer
	} ctrl_sts_t;

endpackage

// ----- rtl/core/oobf_ram.sv -----
// ----------------------------------------------------------------------------
// oobf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module oobf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/oobf_ctrl.sv -----
// ----------------------------------------------------------------------------
// oobf_ctrl
// Handshake controller: accepts one operation at a time, waits in ST_READ for
// the store read on a non-empty pop, and owns the result-valid flag.
// ----------------------------------------------------------------------------
module oobf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  oobf_pkg::ctrl_sts_t  sts,
	output oobf_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   room;

	// result register is free, or is being emptied this cycle
	assign room     = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && room;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.take      = accept;
		cmd.load_now  = accept && !sts.need_read;
		cmd.load_read = (state_q == ST_READ);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.need_read) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_now || cmd.load_read) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/oobf_dp.sv -----
// ----------------------------------------------------------------------------
// oobf_dp
// Datapath: ring indices, fill count, byte store and result register.
// ----------------------------------------------------------------------------
module oobf_dp #(
	parameter int DEPTH = oobf_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [oobf_pkg::KIND_W-1:0]   kind,
	input  logic [oobf_pkg::BYTE_W-1:0]   byte_in,
	input  oobf_pkg::ctrl_cmd_t           cmd,
	output oobf_pkg::ctrl_sts_t           sts,
	output logic [oobf_pkg::BYTE_W-1:0]   byte_out,
	output logic                          byte_valid,
	output logic                          overwrote_oldest,
	output logic [oobf_pkg::FILL_W-1:0]   fill_level
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

	oobf_pkg::kind_t kind_op;

	logic [IDX_W-1:0] wr_q, rd_q, cnt_q;
	logic [IDX_W-1:0] wr_nx, rd_nx, cnt_d;
	logic             full, empty;
	logic             is_ins, is_pop, is_clr;
	logic             drop;
	logic [oobf_pkg::BYTE_W-1:0] rdata;
	logic [IDX_W+oobf_pkg::FILL_W-1:0] cnt_ext_d, cnt_ext_q;

	assign kind_op = oobf_pkg::kind_t'(kind);
	assign full    = (cnt_q == LAST);
	assign empty   = (cnt_q == '0);
	assign wr_nx   = (wr_q == LAST) ? '0 : wr_q + 1'b1;
	assign rd_nx   = (rd_q == LAST) ? '0 : rd_q + 1'b1;

	always_comb begin
		is_ins = 1'b0;
		is_pop = 1'b0;
		is_clr = 1'b0;
		case (kind_op)
			oobf_pkg::KIND_INSERT: is_ins = 1'b1;
			oobf_pkg::KIND_POP:    is_pop = 1'b1;
			oobf_pkg::KIND_CLEAR:  is_clr = 1'b1;
			default: ;
		endcase
	end

	assign sts.need_read = is_pop && !empty;
	assign drop          = is_ins && full;

	// count after the offered operation
	always_comb begin
		cnt_d = cnt_q;
		if (is_ins && !full) begin
			cnt_d = cnt_q + 1'b1;
		end else if (is_pop && !empty) begin
			cnt_d = cnt_q - 1'b1;
		end else if (is_clr) begin
			cnt_d = '0;
		end
	end

	assign cnt_ext_d = {{oobf_pkg::FILL_W{1'b0}}, cnt_d};
	assign cnt_ext_q = {{oobf_pkg::FILL_W{1'b0}}, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.take) begin
			cnt_q <= cnt_d;
			if (is_ins) begin
				wr_q <= wr_nx;
				if (full) begin
					rd_q <= rd_nx;
				end
			end else if (is_pop && !empty) begin
				rd_q <= rd_nx;
			end else if (is_clr) begin
				wr_q <= '0;
				rd_q <= '0;
			end
		end
	end

	oobf_ram #(
		.WIDTH (oobf_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.take && is_ins),
		.waddr (wr_q),
		.wdata (byte_in),
		.re    (cmd.take && sts.need_read),
		.raddr (rd_q),
		.rdata (rdata)
	);

	// result register; count is already updated when read data lands
	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			byte_out         <= '0;
			byte_valid       <= 1'b0;
			overwrote_oldest <= drop;
			fill_level       <= cnt_ext_d[oobf_pkg::FILL_W-1:0];
		end else if (cmd.load_read) begin
			byte_out         <= rdata;
			byte_valid       <= 1'b1;
			overwrote_oldest <= 1'b0;
			fill_level       <= cnt_ext_q[oobf_pkg::FILL_W-1:0];
		end
	end

endmodule

// ----- rtl/core/overwrite_oldest_byte_fifo.sv -----
// ----------------------------------------------------------------------------
// overwrite_oldest_byte_fifo
// Byte ring buffer holding at most DEPTH-1 bytes; an insert into a full
// buffer drops the oldest byte. Supports insert, pop and clear.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser
//  s_*     | in  | [7:0] byte_in                 | [1:0] kind
//  m_*     | out | [7:0] byte_out, [12:8] fill   | [0] byte_valid, [1] overwrote_oldest
//
//  Insert, clear and pop of an empty buffer: result loads in the cycle after
//  the transfer. Pop of a non-empty buffer: via the store's registered read
//  port, then the result register. One operation in flight; the next is taken
//  once the result register is free or being drained. A stalled result holds.
//  Reset clears indices, count and handshake state; the store is not cleared.
// ----------------------------------------------------------------------------
module overwrite_oldest_byte_fifo #(
	parameter int DEPTH = oobf_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] byte_out, [12:8] fill_level, zero pad
	output logic [1:0]  m_tuser    // [0] byte_valid, [1] overwrote_oldest
);

	localparam logic [oobf_pkg::FILL_W-1:0] FULL_FILL =
		oobf_pkg::FILL_W'((DEPTH - 1) % (2 ** oobf_pkg::FILL_W));

	oobf_pkg::ctrl_cmd_t cmd;
	oobf_pkg::ctrl_sts_t sts;

	logic [oobf_pkg::BYTE_W-1:0] byte_out;
	logic                        byte_valid;
	logic                        overwrote_oldest;
	logic [oobf_pkg::FILL_W-1:0] fill_level;

	oobf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	oobf_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.kind             (s_tuser),
		.byte_in          (s_tdata),
		.cmd              (cmd),
		.sts              (sts),
		.byte_out         (byte_out),
		.byte_valid       (byte_valid),
		.overwrote_oldest (overwrote_oldest),
		.fill_level       (fill_level)
	);

	assign m_tdata = {3'b000, fill_level, byte_out};
	assign m_tuser = {overwrote_oldest, byte_valid};

	// never take a new operation while a result is stuck
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(m_tvalid && !m_tready))
		else $error("input taken while result stalled");

	// a dropped byte only happens at the fill limit
	a_drop_at_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[12:8] == FULL_FILL))
		else $error("overwrite reported below full level");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("pop and overwrite flags both set");

	// a pop with data blocks input for the store read cycle
	a_pop_read_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && sts.need_read) |=> !s_tready)
		else $error("input taken during store read");

endmodule
